>>> rtl/acpa_pkg.sv
// Shared types, widths and constants for the calibrated pitch angle block.
// Holds the calibration matrix, the arctangent table and the direction codes.
// Used by every module under rtl; depends on nothing else.
package acpa_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int SAMPLE_BITS_DEF       = 16;

  // Field widths of the stream items.
  localparam int S_W      = 16;  // raw sample field
  localparam int TARGET_W = 11;
  localparam int PITCH_W  = 15;
  localparam int DIR_W    = 2;

  // Datapath widths.
  localparam int COEF_W = 27;            // signed Q.31 matrix entries and offsets
  localparam int PROD_W = S_W + COEF_W;  // sample times matrix entry
  localparam int ACC_W  = PROD_W + 2;    // sum of three products and an offset
  localparam int CAL_W  = 32;            // calibrated axis in Q.23
  localparam int D_W    = 34;            // CORDIC vector components
  localparam int ANG_W  = 33;            // CORDIC angle, 2^30 per quarter turn
  localparam int R_W    = 31;            // root magnitude and gain product operand
  localparam int GP_W   = 2 * R_W;       // gain correction product
  localparam int U_W    = 32;            // clamped angle, 0 .. 2^31
  localparam int SC_W   = U_W + PITCH_W; // angle times 18000
  localparam int BAND_W = 19;            // signed band edges in centidegrees

  localparam logic [R_W-1:0]   GAIN_INV     = R_W'(1304065748);
  localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'd1073741824);
  localparam logic [PITCH_W-1:0] PITCH_MAX  = PITCH_W'(18000);
  localparam int BAND_HALF = 500;
  localparam int CENTI     = 100;

  // Turn direction codes.
  localparam logic [DIR_W-1:0] DIR_CW     = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CCW    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_INSIDE = 2'd2;
  localparam logic [DIR_W-1:0] DIR_EDGE   = 2'd3;

  // Rows 0..2 multiply the x, y and z samples; row 3 is the offset.
  localparam logic signed [COEF_W-1:0] CAL_M [4][3] = '{
    '{ 27'sd2035472,   -27'sd42813,    -27'sd51512   },
    '{ -27'sd48009,    27'sd2071574,   -27'sd22475   },
    '{ 27'sd10197,     -27'sd10462,    27'sd2171305  },
    '{ -27'sd14438630, -27'sd4821243,  -27'sd39742360 }
  };

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
    30'd20,        30'd10,        30'd5,         30'd3,        30'd1,
    30'd1,         30'd0
  };

endpackage

>>> rtl/acpa_calib.sv
// Affine calibration of one raw three-axis sample, three register stages:
// nine products, the rounded sums in Q.23, then the magnitude of the z axis.
// Depends on acpa_pkg.
module acpa_calib #(
  parameter int SAMPLE_BITS = acpa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            valid_i,
  input  logic [acpa_pkg::S_W-1:0]        accel_x,
  input  logic [acpa_pkg::S_W-1:0]        accel_y,
  input  logic [acpa_pkg::S_W-1:0]        accel_z,
  output logic                            valid_o,
  output logic signed [acpa_pkg::CAL_W-1:0] cal_x,
  output logic signed [acpa_pkg::CAL_W-1:0] cal_y,
  output logic signed [acpa_pkg::CAL_W-1:0] abs_z
);
  import acpa_pkg::*;

  logic signed [SAMPLE_BITS-1:0] smp_raw [3];
  logic signed [S_W-1:0]         smp [3];
  logic signed [PROD_W-1:0]      prod [3][3];
  logic signed [ACC_W-1:0]       acc [3];
  logic signed [CAL_W-1:0]       cal [3];
  logic                          v1, v2;

  // Only the low SAMPLE_BITS bits of each field carry the sample.
  assign smp_raw[0] = accel_x[SAMPLE_BITS-1:0];
  assign smp_raw[1] = accel_y[SAMPLE_BITS-1:0];
  assign smp_raw[2] = accel_z[SAMPLE_BITS-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      smp[i] = S_W'(smp_raw[i]);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = ACC_W'(CAL_M[3][j]) + ACC_W'(prod[0][j]) + ACC_W'(prod[1][j])
             + ACC_W'(prod[2][j]) + ACC_W'(128);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      v1      <= valid_i;
      v2      <= v1;
      valid_o <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PROD_W'(smp[i]) * PROD_W'(CAL_M[i][j]);
        end
      end
      for (int j = 0; j < 3; j++) begin
        cal[j] <= acc[j][CAL_W+7:8];
      end
      cal_x <= cal[0];
      cal_y <= cal[1];
      abs_z <= (cal[2] < 0) ? -cal[2] : cal[2];
    end
  end

endmodule

>>> rtl/acpa_cordic_cell.sv
// One vectoring CORDIC cell: a single micro-rotation towards b = 0 with its
// own output register, passing side data along unchanged. Depends on acpa_pkg.
module acpa_cordic_cell #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic signed [acpa_pkg::D_W-1:0]   a_i,
  input  logic signed [acpa_pkg::D_W-1:0]   b_i,
  input  logic signed [acpa_pkg::ANG_W-1:0] ang_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [acpa_pkg::D_W-1:0]   a_o,
  output logic signed [acpa_pkg::D_W-1:0]   b_o,
  output logic signed [acpa_pkg::ANG_W-1:0] ang_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import acpa_pkg::*;

  localparam logic signed [ANG_W-1:0] STEP_ANG = ANG_W'(ATAN_TAB[STAGE]);

  logic signed [D_W-1:0] da, db;

  // Arithmetic shifts round towards minus infinity, as the scheme requires.
  assign da = b_i >>> STAGE;
  assign db = a_i >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      if (b_i >= 0) begin
        a_o   <= a_i + da;
        b_o   <= b_i - db;
        ang_o <= ang_i + STEP_ANG;
      end else begin
        a_o   <= a_i - da;
        b_o   <= b_i + db;
        ang_o <= ang_i - STEP_ANG;
      end
    end
  end

endmodule

>>> rtl/acpa_out.sv
// Output stages: offset and clamp of the angle, scaling to centidegrees with
// rounding, and the comparison with the target band. Depends on acpa_pkg.
module acpa_out (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic signed [acpa_pkg::ANG_W-1:0] ang_i,
  input  logic                              zero_i,
  input  logic [acpa_pkg::TARGET_W-1:0]     target_angle,
  output logic                              valid_o,
  output logic [acpa_pkg::PITCH_W-1:0]      pitch_centideg,
  output logic [acpa_pkg::DIR_W-1:0]        turn_direction
);
  import acpa_pkg::*;

  logic signed [ANG_W:0]     u_full;
  logic [U_W-1:0]            u;
  logic [SC_W-1:0]           scaled;
  logic [SC_W:0]             scaled_rnd;
  logic [SC_W-U_W+1:0]       p_full;
  logic [PITCH_W-1:0]        pitch;
  logic signed [BAND_W-1:0]  band_mid, band_lo, band_hi, pitch_s;
  logic [DIR_W-1:0]          dir;
  logic                      v1, v2, v3;

  // A zero vector has no defined angle and reads as level.
  assign u_full = zero_i ? (ANG_W+1)'(QUARTER_TURN)
                         : (ANG_W+1)'(ang_i) + (ANG_W+1)'(QUARTER_TURN);

  assign scaled_rnd = (SC_W+1)'(scaled) + (SC_W+1)'(QUARTER_TURN);
  assign p_full     = scaled_rnd[SC_W:U_W-1];

  assign band_mid = $signed(BAND_W'(target_angle) * BAND_W'(CENTI));
  assign pitch_s  = $signed(BAND_W'(pitch));

  always_comb begin
    if (pitch_s < band_lo) begin
      dir = DIR_CW;
    end else if (pitch_s > band_hi) begin
      dir = DIR_CCW;
    end else if (pitch_s > band_lo && pitch_s < band_hi) begin
      dir = DIR_INSIDE;
    end else begin
      dir = DIR_EDGE;
    end
  end

  // The band follows the target in the next cycle. The user must change the
  // target only while no item is in flight; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      band_lo <= -BAND_W'(BAND_HALF);
      band_hi <= BAND_W'(BAND_HALF);
    end else begin
      band_lo <= band_mid - BAND_W'(BAND_HALF);
      band_hi <= band_mid + BAND_W'(BAND_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      v1      <= valid_i;
      v2      <= v1;
      v3      <= v2;
      valid_o <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (u_full < 0) begin
        u <= '0;
      end else if (u_full > (ANG_W+1)'(2 * QUARTER_TURN)) begin
        u <= U_W'(2 * QUARTER_TURN);
      end else begin
        u <= u_full[U_W-1:0];
      end
      scaled <= SC_W'(u) * SC_W'(PITCH_MAX);
      pitch  <= (p_full > (SC_W-U_W+2)'(PITCH_MAX)) ? PITCH_MAX : p_full[PITCH_W-1:0];
      pitch_centideg <= pitch;
      turn_direction <= dir;
    end
  end

endmodule

>>> rtl/accel_calibrated_pitch_angle.sv
// Calibrated accelerometer pitch angle with turn guidance.
// Channels: the slave side takes one raw three-axis sample per item; the
// master side gives one result item per sample, in order: the pitch plus
// 90 degrees in hundredths of a degree and the turn direction against the
// target band. cfg_we writes the target angle in whole degrees.
// Throughput: one item per cycle while the skid register is empty. The path
// is a row of registered CORDIC cells, one per iteration for the root and
// again for the arctangent. From acceptance to m_tvalid an item passes
// three calibration stages, the first cell row, two gain correction stages,
// the second cell row and four output stages.
// Reset clears all valid flags and sets the target to 0 degrees.
// When the receiver stalls, the result in the output register moves into a
// skid register, so s_tready falls in the next cycle and no item is lost; the
// whole row then holds until the skid register is emptied.
// Depends on acpa_pkg, acpa_calib, acpa_cordic_cell and acpa_out.
module accel_calibrated_pitch_angle #(
  parameter int CORDIC_ITERATIONS = acpa_pkg::CORDIC_ITERATIONS_DEF,
  parameter int SAMPLE_BITS       = acpa_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // pitch_centideg [14:0], turn_direction [16:15], zero
  input  logic        cfg_we,
  input  logic [acpa_pkg::TARGET_W-1:0] cfg_wdata
);
  import acpa_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  logic                    en;
  logic [TARGET_W-1:0]     target_angle;

  logic                    cal_valid;
  logic signed [CAL_W-1:0] cal_x, cal_y, abs_z;

  logic                    c1_valid [N+1];
  logic signed [D_W-1:0]   c1_a     [N+1];
  logic signed [D_W-1:0]   c1_b     [N+1];
  logic signed [ANG_W-1:0] c1_ang   [N+1];
  logic [CAL_W-1:0]        c1_side  [N+1];

  logic                    g1_valid, g2_valid;
  logic [GP_W-1:0]         g_prod;
  logic [GP_W:0]           g_rnd;
  logic [R_W-1:0]          root;
  logic signed [CAL_W-1:0] g1_cx, g2_cx;
  logic                    g2_zero;
  logic signed [D_W-1:0]   c2_a0;

  logic                    c2_valid [N+1];
  logic signed [D_W-1:0]   c2_a     [N+1];
  logic signed [D_W-1:0]   c2_b     [N+1];
  logic signed [ANG_W-1:0] c2_ang   [N+1];
  logic [0:0]              c2_side  [N+1];

  logic                    out_valid;
  logic [PITCH_W-1:0]      out_pitch;
  logic [DIR_W-1:0]        out_dir;
  logic                    skid_valid;
  logic [PITCH_W-1:0]      skid_pitch;
  logic [DIR_W-1:0]        skid_dir;
  logic [PITCH_W-1:0]      res_pitch;
  logic [DIR_W-1:0]        res_dir;

  assign en       = ~skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle <= '0;
    end else if (cfg_we) begin
      target_angle <= cfg_wdata;
    end
  end

  acpa_calib #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_calib (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid_i (s_tvalid),
    .accel_x (s_tdata[15:0]),
    .accel_y (s_tdata[31:16]),
    .accel_z (s_tdata[47:32]),
    .valid_o (cal_valid),
    .cal_x   (cal_x),
    .cal_y   (cal_y),
    .abs_z   (abs_z)
  );

  // First row: vectoring on (|z|, y) gives the scaled root; x rides along.
  assign c1_valid[0] = cal_valid;
  assign c1_a[0]     = D_W'(abs_z);
  assign c1_b[0]     = D_W'(cal_y);
  assign c1_ang[0]   = '0;
  assign c1_side[0]  = cal_x;

  for (genvar i = 0; i < N; i++) begin : g_row1
    acpa_cordic_cell #(
      .STAGE  (i),
      .SIDE_W (CAL_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_i (c1_valid[i]),
      .a_i     (c1_a[i]),
      .b_i     (c1_b[i]),
      .ang_i   (c1_ang[i]),
      .side_i  (c1_side[i]),
      .valid_o (c1_valid[i+1]),
      .a_o     (c1_a[i+1]),
      .b_o     (c1_b[i+1]),
      .ang_o   (c1_ang[i+1]),
      .side_o  (c1_side[i+1])
    );
  end

  // Gain correction: the scaled root is non-negative and below 2^31.
  assign g_rnd = (GP_W+1)'(g_prod) + (GP_W+1)'(QUARTER_TURN);
  assign root  = g_rnd[GP_W-1:R_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_valid <= 1'b0;
      g2_valid <= 1'b0;
    end else if (en) begin
      g1_valid <= c1_valid[N];
      g2_valid <= g1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_prod  <= GP_W'(c1_a[N][R_W-1:0]) * GP_W'(GAIN_INV);
      g1_cx   <= c1_side[N];
      g2_cx   <= g1_cx;
      g2_zero <= (root == '0) && (g1_cx == '0);
      c2_a0   <= D_W'(root);
    end
  end

  // Second row: vectoring on (root, x) accumulates the arctangent.
  assign c2_valid[0] = g2_valid;
  assign c2_a[0]     = c2_a0;
  assign c2_b[0]     = D_W'(g2_cx);
  assign c2_ang[0]   = '0;
  assign c2_side[0]  = g2_zero;

  for (genvar i = 0; i < N; i++) begin : g_row2
    acpa_cordic_cell #(
      .STAGE  (i),
      .SIDE_W (1)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_i (c2_valid[i]),
      .a_i     (c2_a[i]),
      .b_i     (c2_b[i]),
      .ang_i   (c2_ang[i]),
      .side_i  (c2_side[i]),
      .valid_o (c2_valid[i+1]),
      .a_o     (c2_a[i+1]),
      .b_o     (c2_b[i+1]),
      .ang_o   (c2_ang[i+1]),
      .side_o  (c2_side[i+1])
    );
  end

  acpa_out u_out (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .valid_i        (c2_valid[N]),
    .ang_i          (c2_ang[N]),
    .zero_i         (c2_side[N][0]),
    .target_angle   (target_angle),
    .valid_o        (out_valid),
    .pitch_centideg (out_pitch),
    .turn_direction (out_dir)
  );

  // Skid register: catches the output item when the receiver stalls while
  // the row is still advancing. The skid item is always the older one.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en && out_valid && !m_tready) begin
      skid_valid <= 1'b1;
    end else if (m_tready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && out_valid && !m_tready) begin
      skid_pitch <= out_pitch;
      skid_dir   <= out_dir;
    end
  end

  assign res_pitch = skid_valid ? skid_pitch : out_pitch;
  assign res_dir   = skid_valid ? skid_dir : out_dir;
  assign m_tvalid  = skid_valid | out_valid;
  assign m_tdata   = {7'd0, res_dir, res_pitch};

endmodule
